[rtl/ps2sd_pkg.sv]
// ----------------------------------------------------------------------------
// PS/2 scan set 1 decoder package
// Scan codes, modifier and lock bit positions, and prefix state codes.
// ----------------------------------------------------------------------------
package ps2sd_pkg;

  localparam logic [7:0] ScanExtPrefix   = 8'hE0;
  localparam logic [7:0] ScanPausePrefix = 8'hE1;

  localparam logic [6:0] CodeCtrl   = 7'h1D;
  localparam logic [6:0] CodeLShift = 7'h2A;
  localparam logic [6:0] CodeRShift = 7'h36;
  localparam logic [6:0] CodeAlt    = 7'h38;
  localparam logic [6:0] CodeLGui   = 7'h5B;
  localparam logic [6:0] CodeRGui   = 7'h5C;
  localparam logic [6:0] CodeCaps   = 7'h3A;
  localparam logic [6:0] CodeNum    = 7'h45;
  localparam logic [6:0] CodeScroll = 7'h46;

  localparam logic [7:0] ModLCtrl  = 8'h01;
  localparam logic [7:0] ModLShift = 8'h02;
  localparam logic [7:0] ModLAlt   = 8'h04;
  localparam logic [7:0] ModLGui   = 8'h08;
  localparam logic [7:0] ModRCtrl  = 8'h10;
  localparam logic [7:0] ModRShift = 8'h20;
  localparam logic [7:0] ModRAlt   = 8'h40;
  localparam logic [7:0] ModRGui   = 8'h80;

  localparam logic [2:0] LockCaps   = 3'b001;
  localparam logic [2:0] LockNum    = 3'b010;
  localparam logic [2:0] LockScroll = 3'b100;

  typedef enum logic [3:0] {
    PxNone  = 4'b0001,
    PxExt   = 4'b0010,
    PxSkip2 = 4'b0100,
    PxSkip1 = 4'b1000
  } prefix_e;

endpackage

[rtl/ps2_scancode_decoder.sv]
// ----------------------------------------------------------------------------
// PS/2 scan set 1 decoder
// Turns raw scan set 1 bytes into key events with modifier and lock state.
// ----------------------------------------------------------------------------
// Input channel: one raw scan byte per transaction (in_valid_i/in_ready_o).
// Output channel: one key event per transaction (out_valid_o/out_ready_i),
// carrying the key code (bit 7 marks an E0 extended key), make or break,
// the held modifiers and the lock bits.
// Prefix bytes, the two bytes after E1, modifier keys and lock keys update
// internal state only and produce no event.
// An accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the result register can advance,
// set by the single decode stage between the two registers.
// Reset clears the prefix state, the modifiers, the locks and both valid
// flags. When the receiver stalls, the event is held in the result
// register; the input register keeps accepting until it holds a byte that
// cannot move on, then in_ready_o drops.
// ----------------------------------------------------------------------------
module ps2_scancode_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] key_code_o,
  output logic       is_press_o,
  output logic [7:0] modifier_bits_o,
  output logic [2:0] lock_bits_o
);
  import ps2sd_pkg::*;

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       out_vld_q, out_vld_d;
  logic [7:0] key_code_q;
  logic       is_press_q;
  logic [7:0] mods_q, mods_d;
  logic [2:0] locks_q, locks_d;
  logic [7:0] out_mods_q;
  logic [2:0] out_locks_q;
  prefix_e    prefix_q, prefix_d;

  logic       advance;
  logic       fire;
  logic       is_e0, is_e1, skip, ext, make;
  logic [6:0] code;
  logic [7:0] mod_bit;
  logic [2:0] lock_bit;
  logic       event_hit;

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  assign is_e0 = (byte_q == ScanExtPrefix);
  assign is_e1 = (byte_q == ScanPausePrefix);
  assign skip  = (prefix_q == PxSkip2 || prefix_q == PxSkip1) && !is_e0 && !is_e1;
  assign ext   = (prefix_q == PxExt);
  assign code  = byte_q[6:0];
  assign make  = !byte_q[7];

  always_comb begin
    mod_bit  = '0;
    lock_bit = '0;
    if (ext) begin
      unique case (code)
        CodeCtrl: mod_bit = ModRCtrl;
        CodeAlt:  mod_bit = ModRAlt;
        CodeLGui: mod_bit = ModLGui;
        CodeRGui: mod_bit = ModRGui;
        default:  mod_bit = '0;
      endcase
    end else begin
      unique case (code)
        CodeCtrl:   mod_bit  = ModLCtrl;
        CodeLShift: mod_bit  = ModLShift;
        CodeRShift: mod_bit  = ModRShift;
        CodeAlt:    mod_bit  = ModLAlt;
        CodeCaps:   lock_bit = LockCaps;
        CodeNum:    lock_bit = LockNum;
        CodeScroll: lock_bit = LockScroll;
        default:    mod_bit  = '0;
      endcase
    end
  end

  assign event_hit = !is_e0 && !is_e1 && !skip && (mod_bit == '0) && (lock_bit == '0);

  always_comb begin
    prefix_d = prefix_q;
    mods_d   = mods_q;
    locks_d  = locks_q;
    if (fire) begin
      if (is_e0) begin
        prefix_d = PxExt;
      end else if (is_e1) begin
        prefix_d = PxSkip2;
      end else begin
        unique case (prefix_q)
          PxSkip2: prefix_d = PxSkip1;
          PxSkip1: prefix_d = PxNone;
          PxExt:   prefix_d = PxNone;
          PxNone:  prefix_d = PxNone;
          default: prefix_d = PxNone;
        endcase
        if (!skip) begin
          mods_d = make ? (mods_q | mod_bit) : (mods_q & ~mod_bit);
          if (make) begin
            locks_d = locks_q ^ lock_bit;
          end
        end
      end
    end
  end

  assign out_vld_d = advance ? (in_vld_q && event_hit) : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      prefix_q  <= PxNone;
      mods_q    <= '0;
      locks_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      out_vld_q <= out_vld_d;
      prefix_q  <= prefix_d;
      mods_q    <= mods_d;
      locks_q   <= locks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= scan_byte_i;
    end
    if (fire && event_hit) begin
      key_code_q  <= {ext, code};
      is_press_q  <= make;
      out_mods_q  <= mods_q;
      out_locks_q <= locks_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign key_code_o      = key_code_q;
  assign is_press_o      = is_press_q;
  assign modifier_bits_o = out_mods_q;
  assign lock_bits_o     = out_locks_q;

  a_prefix_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(prefix_q))
    else $error("prefix state not one-hot");

  a_state_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(mods_q) && $stable(locks_q) && $stable(prefix_q))
    else $error("decoder state moved without a byte");

  a_lock_on_make: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(locks_q) |-> $past(fire && !byte_q[7]))
    else $error("lock bits changed without a make code");

  a_skip_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && prefix_q == PxSkip2 && !is_e0 && !is_e1 |=> prefix_q == PxSkip1 && !out_vld_q)
    else $error("pause skip sequence broken");

endmodule

[tb/sv/ps2_scancode_decoder_checker.sv]
// ----------------------------------------------------------------------------
// PS/2 scan set 1 decoder checker
// Watches both channels of the decoder. Every accepted scan byte updates a
// private model of the prefix, modifier and lock state, and every byte that
// should yield a key event queues that event. Every accepted key event is
// compared, field by field, with the oldest queued one.
// ----------------------------------------------------------------------------
module ps2_scancode_decoder_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] scan_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] key_code_i,
  input  logic       is_press_i,
  input  logic [7:0] modifier_bits_i,
  input  logic [2:0] lock_bits_i,
  output int         errors_o,
  output int         pending_o
);
  import ps2sd_pkg::*;

  typedef struct packed {
    logic [7:0] key_code;
    logic       is_press;
    logic [7:0] modifier_bits;
    logic [2:0] lock_bits;
  } key_event_t;

  prefix_e    prefix_st;
  logic [7:0] held_mods;
  logic [2:0] lock_st;
  key_event_t key_event_q[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic logic decode_scan(input logic [7:0] b, output key_event_t ev);
    logic [6:0] code;
    logic       make;
    logic       ext;
    logic [7:0] mod_bit;
    logic [2:0] lock_bit;
    mod_bit  = '0;
    lock_bit = '0;
    ev       = '0;
    if (b == ScanExtPrefix) begin
      prefix_st = PxExt;
      return 1'b0;
    end
    if (b == ScanPausePrefix) begin
      prefix_st = PxSkip2;
      return 1'b0;
    end
    if (prefix_st == PxSkip2) begin
      prefix_st = PxSkip1;
      return 1'b0;
    end
    if (prefix_st == PxSkip1) begin
      prefix_st = PxNone;
      return 1'b0;
    end
    code      = b[6:0];
    make      = ~b[7];
    ext       = (prefix_st == PxExt);
    prefix_st = PxNone;
    if (ext) begin
      case (code)
        CodeCtrl: mod_bit = ModRCtrl;
        CodeAlt:  mod_bit = ModRAlt;
        CodeLGui: mod_bit = ModLGui;
        CodeRGui: mod_bit = ModRGui;
        default: ;
      endcase
    end else begin
      case (code)
        CodeCtrl:   mod_bit  = ModLCtrl;
        CodeLShift: mod_bit  = ModLShift;
        CodeRShift: mod_bit  = ModRShift;
        CodeAlt:    mod_bit  = ModLAlt;
        CodeCaps:   lock_bit = LockCaps;
        CodeNum:    lock_bit = LockNum;
        CodeScroll: lock_bit = LockScroll;
        default: ;
      endcase
    end
    if (mod_bit != '0) begin
      held_mods = make ? (held_mods | mod_bit) : (held_mods & ~mod_bit);
      return 1'b0;
    end
    if (lock_bit != '0) begin
      if (make) lock_st = lock_st ^ lock_bit;
      return 1'b0;
    end
    ev.key_code      = {ext, code};
    ev.is_press      = make;
    ev.modifier_bits = held_mods;
    ev.lock_bits     = lock_st;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    key_event_t want;
    key_event_t got;
    if (!rst_ni) begin
      prefix_st = PxNone;
      held_mods = '0;
      lock_st   = '0;
      key_event_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{key_code_i, is_press_i, modifier_bits_i, lock_bits_i};
        if (key_event_q.size() == 0) begin
          errors_o = errors_o + 1;
          if (errors_o <= 10)
            $display("unexpected key event: code %02h press %0d mods %02h locks %0h",
                     got.key_code, got.is_press, got.modifier_bits, got.lock_bits);
        end else begin
          want = key_event_q.pop_front();
          if (got.key_code !== want.key_code || got.is_press !== want.is_press ||
              got.modifier_bits !== want.modifier_bits ||
              got.lock_bits !== want.lock_bits) begin
            errors_o = errors_o + 1;
            if (errors_o <= 10) begin
              $write("key event mismatch: expected code %02h press %0d mods %02h",
                     want.key_code, want.is_press, want.modifier_bits);
              $write(" locks %0h,", want.lock_bits);
              $display(" got code %02h press %0d mods %02h locks %0h",
                       got.key_code, got.is_press, got.modifier_bits, got.lock_bits);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (decode_scan(scan_byte_i, want)) key_event_q.push_back(want);
      end
    end
    pending_o = key_event_q.size();
  end

endmodule

[tb/sv/ps2_scancode_decoder_test.sv]
// ----------------------------------------------------------------------------
// PS/2 scan set 1 decoder testbench
// Feeds directed scan bytes covering modifiers, locks, extended codes and
// Pause skips, then random well-formed key strokes mixed with broken prefix
// runs, under random idling on both channels. The checker predicts and
// compares; this module drives the traffic and reports the verdict.
// ----------------------------------------------------------------------------
module ps2_scancode_decoder_test;
  import ps2sd_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready_o;
  logic [7:0] scan_byte = 8'h00;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  logic [7:0] key_code_o;
  logic       is_press_o;
  logic [7:0] modifier_bits_o;
  logic [2:0] lock_bits_o;
  int         mismatches;
  int         pending_events;
  int         bytes_sent = 0;

  ps2_scancode_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .scan_byte_i     (scan_byte),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .key_code_o      (key_code_o),
    .is_press_o      (is_press_o),
    .modifier_bits_o (modifier_bits_o),
    .lock_bits_o     (lock_bits_o)
  );

  ps2_scancode_decoder_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready_o),
    .scan_byte_i     (scan_byte),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready),
    .key_code_i      (key_code_o),
    .is_press_i      (is_press_o),
    .modifier_bits_i (modifier_bits_o),
    .lock_bits_i     (lock_bits_o),
    .errors_o        (mismatches),
    .pending_o       (pending_events)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic in_quiet_phase();
    return bytes_sent >= 600 && bytes_sent < 700;
  endfunction

  function automatic logic [6:0] pick_special_key(input logic ext);
    if (ext) begin
      case ($urandom_range(0, 5))
        0: return CodeCtrl;
        1: return CodeAlt;
        2: return CodeLGui;
        3: return CodeRGui;
        4: return CodeLShift;
        default: return CodeRShift;
      endcase
    end
    case ($urandom_range(0, 6))
      0: return CodeCtrl;
      1: return CodeLShift;
      2: return CodeRShift;
      3: return CodeAlt;
      4: return CodeCaps;
      5: return CodeNum;
      default: return CodeScroll;
    endcase
  endfunction

  task automatic send_scan(input logic [7:0] b);
    int gap;
    gap = in_quiet_phase() ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    scan_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    wait (pending_events == 0);
    @(negedge clk_i);
  endtask

  task automatic send_random_stroke();
    int   r;
    logic ext;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_scan(8'($urandom_range(0, 255)));
    end else if (r < 55) begin
      ext = 1'($urandom_range(0, 1));
      if (ext) send_scan(ScanExtPrefix);
      send_scan({1'($urandom_range(0, 1)), pick_special_key(ext)});
    end else if (r < 80) begin
      send_scan(ScanExtPrefix);
      send_scan(8'($urandom_range(0, 255)));
    end else if (r < 90) begin
      send_scan(ScanPausePrefix);
      send_scan(8'($urandom_range(0, 255)));
      send_scan(8'($urandom_range(0, 255)));
    end else begin
      send_scan($urandom_range(0, 1) ? ScanExtPrefix : ScanPausePrefix);
      if ($urandom_range(0, 1)) send_scan(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int   busy;
    int   burst;
    logic held_off;
    held_off = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held_off && bytes_sent >= 300) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        held_off = 1'b1;
      end else begin
        busy = in_quiet_phase() ? 0 : pick_gap();
        if (busy > 0) begin
          out_ready <= 1'b0;
          repeat (busy) @(negedge clk_i);
        end
      end
      out_ready <= 1'b1;
      burst = $urandom_range(1, 8);
      repeat (burst) @(negedge clk_i);
    end
  end

  initial begin
    logic drained;
    drained = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_scan(8'h00);
    send_scan(8'hFF);
    send_scan({1'b0, CodeCtrl});
    send_scan({1'b0, CodeLShift});
    send_scan({1'b0, CodeRShift});
    send_scan({1'b0, CodeAlt});
    send_scan(ScanExtPrefix);
    send_scan({1'b0, CodeCtrl});
    send_scan(ScanExtPrefix);
    send_scan({1'b0, CodeAlt});
    send_scan(ScanExtPrefix);
    send_scan({1'b0, CodeLGui});
    send_scan(ScanExtPrefix);
    send_scan({1'b0, CodeRGui});
    send_scan(8'h1E);
    send_scan({1'b0, CodeCaps});
    send_scan({1'b0, CodeNum});
    send_scan({1'b0, CodeScroll});
    send_scan({1'b1, CodeNum});
    send_scan(ScanExtPrefix);
    send_scan({1'b1, CodeRShift});
    send_scan(ScanPausePrefix);
    send_scan(ScanExtPrefix);
    send_scan({1'b0, CodeLShift});
    send_scan(ScanPausePrefix);
    send_scan({1'b0, CodeCtrl});
    send_scan({1'b0, CodeNum});
    send_scan(ScanExtPrefix);
    send_scan(ScanExtPrefix);
    send_scan(8'h80);
    drain_events();

    while (bytes_sent < 880) begin
      if (!drained && bytes_sent >= 450) begin
        drain_events();
        drained = 1'b1;
      end
      send_random_stroke();
    end
    in_valid <= 1'b0;

    wait (pending_events == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_events == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
